// File: sv/b64d_pkg.sv
// ---------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the character decode function for the base64 to
// little-endian word decoder.
// ---------------------------------------------------------------------------
package b64d_pkg;

   localparam int CHAR_W   = 8;
   localparam int SEXTET_W = 6;
   localparam int WORD_W   = 32;
   localparam int BYTE_W   = 8;

   localparam logic [CHAR_W-1:0] CHAR_PAD   = 8'h3D;  // '='
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_CHAR = 2'd1,
      STATUS_BAD_SIZE = 2'd2
   } status_type;

   // Decoder state carried from one character to the next.
   // Only the most recent sextet can still hold bits that are not yet in a
   // byte, so six accumulator bits are enough.
   typedef struct packed {
      logic [SEXTET_W-1:0] acc;
      logic [2:0]          pending;
      logic [23:0]         partial;
      logic [1:0]          byte_pos;
      logic                pad_seen;
      logic                err_seen;
   } dec_state_type;

   // One result item
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              word_valid;
      logic              finished;
      status_type        status;
   } rsp_item_type;

   // Decoded character: valid flag and the six-bit value
   typedef struct packed {
      logic                valid;
      logic [SEXTET_W-1:0] value;
   } sextet_type;

   // Map a character of the standard alphabet to its six-bit value
   function automatic sextet_type sextet_of(input logic [CHAR_W-1:0] c);
      sextet_type s;
      s.valid = 1'b1;
      s.value = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         s.value = SEXTET_W'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         s.value = SEXTET_W'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         s.value = SEXTET_W'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         s.value = 6'd62;
      end else if (c == 8'h2F) begin
         s.value = 6'd63;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage

// File: sv/b64d_if.sv
// ---------------------------------------------------------------------------
// b64d_if
// Valid/ready channels of the decoder: character items in, word results out.
// ---------------------------------------------------------------------------
interface b64d_req_if;
   logic                          valid;
   logic                          ready;
   logic [b64d_pkg::CHAR_W-1:0]   character;
   logic                          end_of_text;

   modport source (output valid, character, end_of_text, input ready);
   modport sink   (input valid, character, end_of_text, output ready);
endinterface

interface b64d_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [b64d_pkg::WORD_W-1:0]   word;
   logic                          word_valid;
   logic                          finished;
   logic [1:0]                    status;

   modport source (output valid, word, word_valid, finished, status, input ready);
   modport sink   (input valid, word, word_valid, finished, status, output ready);
endinterface

// File: sv/b64d_step.sv
// ---------------------------------------------------------------------------
// b64d_step
// Next-state and result logic for one character: classify, shift six bits
// in, cut out a byte, pack it into the word and decide on a result.
// ---------------------------------------------------------------------------
module b64d_step (
   input  b64d_pkg::dec_state_type          state_cur,
   input  logic [b64d_pkg::CHAR_W-1:0]      character,
   input  logic                             end_of_text,
   output b64d_pkg::dec_state_type          state_nxt,
   output b64d_pkg::rsp_item_type           result,
   output logic                             has_result
);

   b64d_pkg::sextet_type                     sx;
   logic                                     blank;
   logic [2*b64d_pkg::SEXTET_W-1:0]          acc_wide;
   logic [3:0]                               pend_sum;
   logic [2:0]                               shift;
   logic [2*b64d_pkg::SEXTET_W-1:0]          shifted;
   logic [b64d_pkg::BYTE_W-1:0]              new_byte;
   logic                                     have_word;
   logic [b64d_pkg::WORD_W-1:0]              word_out;

   // Classify the character
   always_comb begin
      sx    = b64d_pkg::sextet_of(character);
      blank = (character == b64d_pkg::CHAR_SPACE) || (character inside {[8'h09:8'h0D]});
   end

   // Shift the sextet in and cut out a byte when eight bits are ready
   always_comb begin
      acc_wide = {state_cur.acc, sx.value};
      pend_sum = {1'b0, state_cur.pending} + 4'd6;
      shift    = 3'(pend_sum - 4'd8);
      shifted  = acc_wide >> shift;
      new_byte = shifted[b64d_pkg::BYTE_W-1:0];
   end

   // Advance state and build the result
   always_comb begin
      state_nxt         = state_cur;
      have_word         = 1'b0;
      word_out          = '0;
      has_result        = 1'b0;
      result.word       = '0;
      result.word_valid = 1'b0;
      result.finished   = 1'b0;
      result.status     = b64d_pkg::STATUS_OK;

      if (state_cur.err_seen) begin
         // drop the rest of a bad string
         if (end_of_text) begin
            state_nxt = '0;
         end
      end else begin
         if (!state_cur.pad_seen && !blank) begin
            if (character == b64d_pkg::CHAR_PAD) begin
               state_nxt.pad_seen = 1'b1;
            end else if (!sx.valid) begin
               // report the bad character at once
               has_result       = 1'b1;
               result.finished  = 1'b1;
               result.status    = b64d_pkg::STATUS_BAD_CHAR;
               state_nxt.err_seen = 1'b1;
            end else begin
               state_nxt.acc = sx.value;
               if (pend_sum >= 4'd8) begin
                  state_nxt.pending = shift;
                  case (state_cur.byte_pos)
                     2'd0: state_nxt.partial = {16'd0, new_byte};
                     2'd1: state_nxt.partial = {8'd0, new_byte, state_cur.partial[7:0]};
                     2'd2: state_nxt.partial = {new_byte, state_cur.partial[15:0]};
                     2'd3: begin
                        have_word         = 1'b1;
                        word_out          = {new_byte, state_cur.partial};
                        state_nxt.partial = '0;
                     end
                     default: state_nxt.partial = state_cur.partial;
                  endcase
                  state_nxt.byte_pos = state_cur.byte_pos + 2'd1;
               end else begin
                  state_nxt.pending = pend_sum[2:0];
               end
            end
         end

         if (!sx.valid && !blank && !state_cur.pad_seen &&
             character != b64d_pkg::CHAR_PAD) begin
            // error result already set; a final bad character resets
            if (end_of_text) begin
               state_nxt = '0;
            end
         end else if (end_of_text) begin
            has_result        = 1'b1;
            result.finished   = 1'b1;
            result.word       = word_out;
            result.word_valid = have_word;
            if (!have_word && state_nxt.byte_pos != 2'd0) begin
               result.status = b64d_pkg::STATUS_BAD_SIZE;
            end
            state_nxt = '0;
         end else if (have_word) begin
            has_result        = 1'b1;
            result.word       = word_out;
            result.word_valid = 1'b1;
         end
      end
   end

endmodule

// File: sv/base64_to_le_word_decoder_core.sv
// ---------------------------------------------------------------------------
// base64_to_le_word_decoder_core
// Decodes a base64 character stream into little-endian 32-bit words.
//
//   channel  dir  handshake      payload
//   req_if   in   valid/ready    character[7:0], end_of_text
//   rsp_if   out  valid/ready    word[31:0], word_valid, finished, status[1:0]
//
// One character per cycle while the result side is not stalled: an item sits
// in the input register, where the decode step runs, and its result, if any,
// is registered into the output register.
// Synchronous reset clears the decoder state and both valid flags.
// A stalled result holds the output register, the input register and the
// decoder state; the input register keeps accepting while the output register is empty or being taken.
// ---------------------------------------------------------------------------
module base64_to_le_word_decoder_core (
   input  logic        clock,
   input  logic        reset,
   b64d_req_if.sink    req_if,
   b64d_rsp_if.source  rsp_if
);

   // Input register
   logic                             in_valid_ff;
   logic [b64d_pkg::CHAR_W-1:0]      in_char_ff;
   logic                             in_eot_ff;

   // Decoder state
   b64d_pkg::dec_state_type          state_ff;
   b64d_pkg::dec_state_type          state_in;

   // Output register
   logic                             out_valid_ff;
   b64d_pkg::rsp_item_type           out_item_ff;

   b64d_pkg::rsp_item_type           step_result;
   logic                             step_has_result;
   logic                             out_free;
   logic                             step_fire;
   logic                             req_fire;

   assign out_free  = !out_valid_ff || rsp_if.ready;
   assign step_fire = in_valid_ff && out_free;
   assign req_fire  = req_if.valid && req_if.ready;

   assign req_if.ready = !in_valid_ff || step_fire;

   b64d_step u_step (
      .state_cur   (state_ff),
      .character   (in_char_ff),
      .end_of_text (in_eot_ff),
      .state_nxt   (state_in),
      .result      (step_result),
      .has_result  (step_has_result)
   );

   // Capture incoming items
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
      if (req_fire) begin
         in_char_ff <= req_if.character;
         in_eot_ff  <= req_if.end_of_text;
      end
   end

   // Advance decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   // Hold or load the result
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step_fire && step_has_result;
      end
      if (step_fire && step_has_result) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.word       = out_item_ff.word;
   assign rsp_if.word_valid = out_item_ff.word_valid;
   assign rsp_if.finished   = out_item_ff.finished;
   assign rsp_if.status     = out_item_ff.status;

   // A result without a word always ends a string
   a_nonfinal_has_word: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_item_ff.word_valid || out_item_ff.finished))
      else $error("result without word is not final");

   // An error result never carries a word
   a_error_no_word: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.status != b64d_pkg::STATUS_OK) |->
      (!out_item_ff.word_valid && out_item_ff.word == '0))
      else $error("error result carries a word");

   // An empty output register never blocks the input
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_if.ready)
      else $error("input stalled with free output register");

   // The final character of a string clears the decoder state
   a_clear_at_end: assert property (@(posedge clock) disable iff (reset)
      (step_fire && in_eot_ff) |=> (state_ff == '0))
      else $error("state not cleared after end of text");

endmodule

// File: verif/b64d_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64d_checker
// Watches both channels of the base64 decoder. Each accepted character item
// steps a local decode model that predicts the resulting word items. Each
// accepted result item is compared field by field with the oldest one.
// ---------------------------------------------------------------------------
module b64d_checker (
   input  logic        clock,
   input  logic        reset,
   b64d_req_if         req_mon,
   b64d_rsp_if         rsp_mon,
   output int unsigned fail_count,
   output int unsigned expected_left
);

   // Decode state, one string at a time
   typedef struct packed {
      logic [13:0] acc_bits;
      logic [3:0]  pend;
      logic [23:0] part;
      logic [1:0]  pos;
      logic        pad;
      logic        err;
   } decode_state_type;

   decode_state_type          dec_q;
   b64d_pkg::rsp_item_type    word_q[$];
   int unsigned               mismatch_count;

   // Six-bit value of an alphabet character; returns 0 for anything else
   function automatic logic alphabet_value(input logic [7:0] ch, output logic [5:0] val);
      val = '0;
      alphabet_value = 1'b1;
      if (ch >= "A" && ch <= "Z") begin
         val = 6'(ch - "A");
      end else if (ch >= "a" && ch <= "z") begin
         val = 6'(ch - "a" + 26);
      end else if (ch >= "0" && ch <= "9") begin
         val = 6'(ch - "0" + 52);
      end else if (ch == "+") begin
         val = 6'd62;
      end else if (ch == "/") begin
         val = 6'd63;
      end else begin
         alphabet_value = 1'b0;
      end
   endfunction

   // Advance the decode state by one character and queue any word item
   task automatic decode_char(input logic [7:0] ch, input logic last);
      logic [5:0]             val;
      logic [7:0]             byte_val;
      logic [3:0]             shift;
      logic                   word_done;
      logic [31:0]            word_val;
      b64d_pkg::rsp_item_type item;
      word_done = 1'b0;
      word_val  = '0;
      item      = '0;
      // drop the rest of a string that already failed
      if (dec_q.err) begin
         if (last) dec_q = '0;
         return;
      end
      if (!dec_q.pad && !(ch == b64d_pkg::CHAR_SPACE || (ch >= 8'h09 && ch <= 8'h0D))) begin
         if (ch == b64d_pkg::CHAR_PAD) begin
            dec_q.pad = 1'b1;
         end else if (!alphabet_value(ch, val)) begin
            item.finished = 1'b1;
            item.status   = b64d_pkg::STATUS_BAD_CHAR;
            word_q.insert(word_q.size(), item);
            if (last) dec_q = '0;
            else dec_q.err = 1'b1;
            return;
         end else begin
            dec_q.acc_bits = {dec_q.acc_bits[7:0], val};
            dec_q.pend     = dec_q.pend + 4'd6;
            // pull out a whole byte and pack it little-endian
            if (dec_q.pend >= 4'd8) begin
               shift      = dec_q.pend - 4'd8;
               byte_val   = 8'(dec_q.acc_bits >> shift);
               dec_q.pend = shift;
               if (dec_q.pos == 2'd3) begin
                  word_val  = {byte_val, dec_q.part};
                  word_done = 1'b1;
                  dec_q.part = '0;
                  dec_q.pos  = '0;
               end else begin
                  dec_q.part = dec_q.part | (24'(byte_val) << (8 * dec_q.pos));
                  dec_q.pos  = dec_q.pos + 2'd1;
               end
            end
         end
      end
      if (last) begin
         item.finished = 1'b1;
         if (word_done) begin
            item.word       = word_val;
            item.word_valid = 1'b1;
         end else if (dec_q.pos != 2'd0) begin
            item.status = b64d_pkg::STATUS_BAD_SIZE;
         end else begin
            item.status = b64d_pkg::STATUS_OK;
         end
         word_q.insert(word_q.size(), item);
         dec_q = '0;
      end else if (word_done) begin
         item.word       = word_val;
         item.word_valid = 1'b1;
         word_q.insert(word_q.size(), item);
      end
   endtask

   // Compare one accepted result item with the oldest prediction
   task automatic check_word(input b64d_pkg::rsp_item_type got);
      b64d_pkg::rsp_item_type exp;
      if (word_q.size() == 0) begin
         fail_count++;
         if (mismatch_count < 10)
            $display("%0t: unexpected result word=%h wv=%0d fin=%0d st=%0d", $realtime,
                     got.word, got.word_valid, got.finished, got.status);
         mismatch_count++;
         return;
      end
      exp = word_q.pop_front();
      if (got.word !== exp.word || got.word_valid !== exp.word_valid ||
          got.finished !== exp.finished || got.status !== exp.status) begin
         fail_count++;
         if (mismatch_count < 10)
            $display({"%0t: mismatch exp word=%h wv=%0d fin=%0d st=%0d",
                      " got word=%h wv=%0d fin=%0d st=%0d"},
                     $realtime, exp.word, exp.word_valid, exp.finished, exp.status,
                     got.word, got.word_valid, got.finished, got.status);
         mismatch_count++;
      end
   endtask

   // Compare results first, then predict from the character taken this edge
   always @(posedge clock) begin
      if (reset) begin
         dec_q = '0;
         word_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready)
            check_word({rsp_mon.word, rsp_mon.word_valid, rsp_mon.finished,
                        b64d_pkg::status_type'(rsp_mon.status)});
         if (req_mon.valid && req_mon.ready)
            decode_char(req_mon.character, req_mon.end_of_text);
      end
      expected_left = word_q.size();
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives base64 strings into the decoder: a few directed strings for the
// corner cases, then random strings, mostly well formed with whitespace,
// padding and size errors, plus broken and noise strings. Both channels idle
// in random bursts; one long result stall and one sender pause are included.
// ---------------------------------------------------------------------------
module tb;

   localparam int          ITEM_TARGET = 1700;
   localparam int          HOLD_CYCLES = 80;
   localparam int          IDLE_LIMIT  = 1000;
   localparam string       B64_CHARS   =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam logic [7:0]  BLANKS[6]   = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned fail_count;
   int unsigned expected_left;
   int unsigned items_sent;
   int unsigned idle_cycles;
   bit          sender_idle_on   = 1'b1;
   bit          receiver_idle_on = 1'b1;
   bit          hold_now         = 1'b0;
   logic [7:0]  text_q[$];

   b64d_req_if req_ch ();
   b64d_rsp_if rsp_ch ();

   base64_to_le_word_decoder_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   b64d_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .expected_left (expected_left)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.character   = '0;
      req_ch.end_of_text = 1'b0;
      rsp_ch.ready       = 1'b0;
   end

   // Plain characters: alphabet, padding or whitespace
   function automatic logic char_is_plain(input logic [7:0] ch);
      return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z") ||
             (ch >= "0" && ch <= "9") || ch == "+" || ch == "/" ||
             ch == b64d_pkg::CHAR_PAD || ch == b64d_pkg::CHAR_SPACE ||
             (ch >= 8'h09 && ch <= 8'h0D);
   endfunction

   // Offer one character item, with an optional idle burst first
   task automatic send_char(input logic [7:0] ch, input logic last);
      @(negedge clock);
      if (sender_idle_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.character   <= ch;
      req_ch.end_of_text <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Send the queued string, flagging its final character
   task automatic send_text();
      logic dropped;
      dropped = 1'b0;
      foreach (text_q[i]) begin
         if (!dropped) items_sent++;
         if (!char_is_plain(text_q[i])) dropped = 1'b1;
         send_char(text_q[i], i == text_q.size() - 1);
      end
   endtask

   // Build a random string: mostly well formed, some padded, broken or noise
   task automatic make_random_text(input int unsigned max_words);
      int unsigned kind;
      int unsigned words;
      int unsigned n_chars;
      logic [7:0]  ch;
      text_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 8))
            text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
      end else begin
         words   = ($urandom_range(0, 11) == 0) ? max_words : $urandom_range(0, 4);
         n_chars = (words * 32 + 5) / 6;
         // extra characters leave stray bytes or bits
         if (kind < 30) n_chars += $urandom_range(1, 4);
         repeat (n_chars) begin
            if ($urandom_range(0, 11) == 0)
               text_q.insert(text_q.size(), BLANKS[$urandom_range(0, 5)]);
            text_q.insert(text_q.size(), B64_CHARS[$urandom_range(0, 63)]);
         end
         // padding followed by junk that must be ignored
         if (kind >= 30 && kind < 45) begin
            repeat ($urandom_range(1, 2)) text_q.insert(text_q.size(), b64d_pkg::CHAR_PAD);
            repeat ($urandom_range(0, 3))
               text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
         end
         // one invalid character at a random place
         if (kind >= 45 && kind < 55) begin
            do ch = 8'($urandom_range(0, 255)); while (char_is_plain(ch));
            text_q.insert($urandom_range(0, text_q.size()), ch);
         end
      end
      if (text_q.size() == 0) text_q.insert(0, BLANKS[$urandom_range(0, 5)]);
   endtask

   // Result side: random stall bursts, and one long hold on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_now) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_now = 1'b0;
            rsp_ch.ready <= 1'b1;
         end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run after too many cycles with no item moving
   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb failed");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      items_sent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty string ended by whitespace
      text_q = '{" "};
      send_text();
      // word completes on the final character
      text_q = '{"/", "/", "/", "/", "/", "/"};
      send_text();
      // whitespace inside, padding, unchecked junk after it, leftover bytes
      text_q = '{"A", "A", 8'h09, "A", "A", "=", 8'hFF};
      send_text();
      // invalid character mid-string, rest dropped
      text_q = '{"a", 8'h00, "b", 8'h0A};
      send_text();
      // invalid character as the final one
      text_q = '{8'h80};
      send_text();
      // word mid-string, then a final whitespace with nothing left over
      text_q = '{"0", "9", 8'h0B, "+", "/", 8'h0C, "A", "B", 8'h0D};
      send_text();

      while (items_sent < 700) begin
         make_random_text($urandom_range(6, 16));
         send_text();
      end

      // stall results while characters keep coming, then drain
      sender_idle_on = 1'b0;
      hold_now       = 1'b1;
      make_random_text(0);
      text_q.delete();
      repeat ((20 * 32 + 5) / 6)
         text_q.insert(text_q.size(), B64_CHARS[$urandom_range(0, 63)]);
      send_text();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait (expected_left == 0);
      sender_idle_on = 1'b1;

      while (items_sent < 1400) begin
         make_random_text($urandom_range(6, 16));
         send_text();
      end

      // no idling on either side for the last part
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      while (items_sent < ITEM_TARGET) begin
         make_random_text($urandom_range(6, 16));
         send_text();
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait (expected_left == 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
